// File: src/kti_pkg.sv
package kti_pkg;

  // table geometry and arithmetic widths
  localparam int KEYS = 64;
  localparam int AW   = $clog2(KEYS);
  localparam int CW   = $clog2(KEYS + 1);
  localparam int VW   = 32;
  localparam int TW   = 16;
  localparam int DCW  = $clog2(TW);
  localparam int HW   = 40;
  localparam int PW   = HW + TW + 1;

  // configuration register byte address
  localparam logic [1:0] REG_LOOP_ADDR = 2'd0;

  typedef enum logic [1:0] {
    FN_PUT   = 2'd0,
    FN_EVAL  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NEG   = 2'd3
  } status_t;

  // one stored keyframe
  typedef struct packed {
    logic signed [VW-1:0] stamp;
    logic signed [VW-1:0] ex;
    logic signed [VW-1:0] ey;
    logic signed [VW-1:0] ez;
    logic signed [VW-1:0] lx;
    logic signed [VW-1:0] ly;
    logic signed [VW-1:0] lz;
    logic                 spl;
  } key_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_SH_RD, S_SH_WR, S_WRITE,
    S_F0, S_F1, S_F2, S_F3, S_DIV, S_AR_INIT, S_AR_MUL, S_AR_ADD, S_AR_STORE, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RD_IDX, RD_JM1, RD_PV, RD_BI, RD_AI
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO, RES_NX_LEAVE, RES_NX_ENTRY, RES_PV_LEAVE
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     item_load;
    logic     idx_clr;
    logic     idx_inc;
    logic     scan_stop;
    logic     j_load;
    logic     j_dec;
    rd_sel_t  rd_sel;
    logic     we;
    logic     wr_shift;
    logic     count_inc;
    logic     count_clr;
    logic     pv_load;
    logic     bi_load;
    logic     ai_load;
    logic     div_start;
    logic     div_step;
    logic     ar_init;
    logic     ar_mul;
    logic     ar_add;
    logic     ar_store;
    logic     res_load;
    res_sel_t res_sel;
    status_t  stat;
    logic     out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t func;
    logic  when_neg;
    logic  count_zero;
    logic  full;
    logic  idx_at_end;
    logic  idx_zero;
    logic  stamp_lt;
    logic  hit;
    logic  j_eq_idx;
    logic  div_last;
    logic  step_last;
    logic  comp_last;
  } stat_t;

  function automatic logic signed [VW-1:0] leave_of(key_t k, logic [1:0] c);
    case (c)
      2'd0:    return k.lx;
      2'd1:    return k.ly;
      default: return k.lz;
    endcase
  endfunction

  function automatic logic signed [VW-1:0] entry_of(key_t k, logic [1:0] c);
    case (c)
      2'd0:    return k.ex;
      2'd1:    return k.ey;
      default: return k.ez;
    endcase
  endfunction

  function automatic logic distinct(key_t k);
    return (k.ex != k.lx) || (k.ey != k.ly) || (k.ez != k.lz);
  endfunction

  // clamp a wide signed value into the result range
  function automatic logic signed [VW-1:0] sat_v(logic signed [HW-1:0] v);
    logic [HW-VW:0] top;
    top = v[HW-1:VW-1];
    if (top == '0 || top == '1) begin
      return v[VW-1:0];
    end else if (v[HW-1]) begin
      return {1'b1, {(VW-1){1'b0}}};
    end else begin
      return {1'b0, {(VW-1){1'b1}}};
    end
  endfunction

endpackage

// File: src/kti_if.sv
interface kti_in_if;
  import kti_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic signed [VW-1:0] when_q;
  logic signed [VW-1:0] entry_x;
  logic signed [VW-1:0] entry_y;
  logic signed [VW-1:0] entry_z;
  logic signed [VW-1:0] leave_x;
  logic signed [VW-1:0] leave_y;
  logic signed [VW-1:0] leave_z;
  logic                 spline_sel;
  modport source (output valid, func, when_q, entry_x, entry_y, entry_z,
                  leave_x, leave_y, leave_z, spline_sel, input ready);
  modport sink (input valid, func, when_q, entry_x, entry_y, entry_z,
                leave_x, leave_y, leave_z, spline_sel, output ready);
endinterface

interface kti_out_if;
  import kti_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] res_x;
  logic signed [VW-1:0] res_y;
  logic signed [VW-1:0] res_z;
  logic [1:0]           status;
  modport source (output valid, res_x, res_y, res_z, status, input ready);
  modport sink (input valid, res_x, res_y, res_z, status, output ready);
endinterface

// File: src/keyframe_track_interpolator.sv
// Keyframe track interpolator.
// in_item carries one item: a put (insert or overwrite a keyframe), an
// evaluate (sample the track at a time) or a clear. Every item returns
// exactly one result on out_item: the evaluated 3-vector and a status code.
// The APB port holds one register, loop_enable, at address 0.
// Items run one at a time through a state machine over a key table with
// one read port and one write port, read one entry per cycle. A clear,
// ignored or rejected item finishes without a search. A put searches for
// its position, then overwrites a key of the same time, reports full, or
// moves later keys up one slot and inserts the new one. An evaluate
// searches too: a hit returns that key's leave value and a time before the
// first key returns its entry value; else the previous key and the two
// outer neighbors are fetched, a time past the last key returns the
// previous key's leave value, and between two keys the divider forms the
// blend fraction for a linear or spline horner evaluation.
// The next item is taken while a result still waits in the output
// register; a stalled receiver holds the block once the following result
// is ready. Reset empties the track and clears loop_enable; key entries
// are not cleared and need no clearing pass.
module keyframe_track_interpolator (
  input  logic       clk,
  input  logic       rst_n,
  kti_in_if.sink     in_item,
  kti_out_if.source  out_item,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import kti_pkg::*;

  logic  loop_r;
  cmd_t  cmd;
  stat_t stat;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_LOOP_ADDR) begin
      loop_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_LOOP_ADDR) ? {31'b0, loop_r} : 32'b0;

  kti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kti_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .loop_en    (loop_r),
    .func       (in_item.func),
    .when_q     (in_item.when_q),
    .entry_x    (in_item.entry_x),
    .entry_y    (in_item.entry_y),
    .entry_z    (in_item.entry_z),
    .leave_x    (in_item.leave_x),
    .leave_y    (in_item.leave_y),
    .leave_z    (in_item.leave_z),
    .spline_sel (in_item.spline_sel),
    .cmd        (cmd),
    .stat       (stat),
    .res_x      (out_item.res_x),
    .res_y      (out_item.res_y),
    .res_z      (out_item.res_z),
    .status     (out_item.status)
  );

endmodule

// File: src/kti_ctrl.sv
module kti_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  kti_pkg::stat_t  stat,
  output kti_pkg::cmd_t   cmd
);
  import kti_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // state and output handshake registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_START;
        end
      end
      S_START: begin
        case (stat.func)
          FN_PUT: begin
            if (stat.when_neg) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ZERO;
              cmd.stat     = ST_NEG;
              state_nxt    = S_DONE;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_SCAN_RD;
            end
          end
          FN_EVAL: begin
            if (stat.count_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_ZERO;
              cmd.stat     = ST_EMPTY;
              state_nxt    = S_DONE;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_SCAN_RD;
            end
          end
          FN_CLEAR: begin
            cmd.count_clr = 1'b1;
            cmd.res_load  = 1'b1;
            cmd.res_sel   = RES_ZERO;
            cmd.stat      = ST_OK;
            state_nxt     = S_DONE;
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ZERO;
            cmd.stat     = ST_OK;
            state_nxt    = S_DONE;
          end
        endcase
      end
      // linear search for the first key not before the query time
      S_SCAN_RD: begin
        cmd.rd_sel = RD_IDX;
        state_nxt  = stat.idx_at_end ? S_DECIDE : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.stamp_lt) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end else begin
          cmd.scan_stop = 1'b1;
          state_nxt     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.func == FN_PUT) begin
          if (stat.hit) begin
            state_nxt = S_WRITE;
          end else if (stat.full) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ZERO;
            cmd.stat     = ST_FULL;
            state_nxt    = S_DONE;
          end else begin
            cmd.j_load = 1'b1;
            state_nxt  = S_SH_RD;
          end
        end else if (stat.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_NX_LEAVE;
          cmd.stat     = ST_OK;
          state_nxt    = S_DONE;
        end else if (stat.idx_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_NX_ENTRY;
          cmd.stat     = ST_OK;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_F0;
        end
      end
      // move entries up one slot to open the insert position
      S_SH_RD: begin
        if (stat.j_eq_idx) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.rd_sel = RD_JM1;
          state_nxt  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.we       = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.j_dec    = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_WRITE: begin
        cmd.we        = 1'b1;
        cmd.count_inc = !stat.hit;
        cmd.res_load  = 1'b1;
        cmd.res_sel   = RES_ZERO;
        cmd.stat      = ST_OK;
        state_nxt     = S_DONE;
      end
      // fetch previous key and the two outer neighbors
      S_F0: begin
        cmd.rd_sel = RD_PV;
        state_nxt  = S_F1;
      end
      S_F1: begin
        cmd.rd_sel  = RD_BI;
        cmd.pv_load = 1'b1;
        state_nxt   = S_F2;
      end
      S_F2: begin
        cmd.rd_sel  = RD_AI;
        cmd.bi_load = 1'b1;
        state_nxt   = S_F3;
      end
      S_F3: begin
        cmd.ai_load = 1'b1;
        if (stat.idx_at_end) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_PV_LEAVE;
          cmd.stat     = ST_OK;
          state_nxt    = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_AR_INIT;
        end
      end
      // horner evaluation, one component at a time
      S_AR_INIT: begin
        cmd.ar_init = 1'b1;
        state_nxt   = S_AR_MUL;
      end
      S_AR_MUL: begin
        cmd.ar_mul = 1'b1;
        state_nxt  = S_AR_ADD;
      end
      S_AR_ADD: begin
        cmd.ar_add = 1'b1;
        state_nxt  = stat.step_last ? S_AR_STORE : S_AR_MUL;
      end
      S_AR_STORE: begin
        cmd.ar_store = 1'b1;
        state_nxt    = stat.comp_last ? S_DONE : S_AR_INIT;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_START)
    else $error("accepted item did not start processing");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && out_valid_r && !out_ready |=> state_r == S_DONE && out_valid_r)
    else $error("finished result lost under stall");

endmodule

// File: src/kti_dp.sv
module kti_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         loop_en,
  input  logic [1:0]                   func,
  input  logic signed [kti_pkg::VW-1:0] when_q,
  input  logic signed [kti_pkg::VW-1:0] entry_x,
  input  logic signed [kti_pkg::VW-1:0] entry_y,
  input  logic signed [kti_pkg::VW-1:0] entry_z,
  input  logic signed [kti_pkg::VW-1:0] leave_x,
  input  logic signed [kti_pkg::VW-1:0] leave_y,
  input  logic signed [kti_pkg::VW-1:0] leave_z,
  input  logic                         spline_sel,
  input  kti_pkg::cmd_t                cmd,
  output kti_pkg::stat_t               stat,
  output logic signed [kti_pkg::VW-1:0] res_x,
  output logic signed [kti_pkg::VW-1:0] res_y,
  output logic signed [kti_pkg::VW-1:0] res_z,
  output logic [1:0]                   status
);
  import kti_pkg::*;

  key_t                 mem [KEYS];
  key_t                 rd_q_r;
  key_t                 item_r, nxe_r, pv_r, bi_r, ai_r;
  logic [1:0]           func_r;
  logic [CW-1:0]        count_r, idx_r, j_r;
  logic                 hit_r;
  logic [VW-1:0]        rem_r, den_r;
  logic [TW-1:0]        t_r;
  logic [DCW-1:0]       dcnt_r;
  logic [1:0]           comp_r, step_r;
  logic signed [HW-1:0] h_r;
  logic signed [PW-1:0] prod_r;
  logic signed [VW-1:0] res_r [3];
  status_t              status_r;
  logic signed [VW-1:0] out_x_r, out_y_r, out_z_r;
  status_t              out_st_r;

  logic signed [VW-1:0] q;
  logic [CW-1:0]        pv_idx, bi_idx, ai_idx;
  logic                 wrap, hb, ha, ha_raw, spline;
  logic [AW-1:0]        rd_addr, wr_addr;
  key_t                 wr_data;
  logic [VW:0]          rem2, rem2_sub;
  logic signed [VW-1:0] p0, p1, p2, p3;
  logic signed [HW-1:0] p0e, p1e, p2e, p3e, d0, d1, dd, coef_a, coef_b, init_v, coef;
  logic signed [HW-1:0] prod_sh, fin_v;

  function automatic logic signed [VW-1:0] when_q_r_clamp(logic signed [VW-1:0] w);
    return w[VW-1] ? '0 : w;
  endfunction

  // query time clamped at zero
  assign q = when_q_r_clamp(item_r.stamp);

  // neighbor indices, with optional wrap around the track
  assign wrap   = loop_en && (count_r >= CW'(3));
  assign pv_idx = idx_r - CW'(1);
  assign bi_idx = (idx_r > CW'(1)) ? idx_r - CW'(2) : count_r - CW'(2);
  assign hb     = (idx_r > CW'(1)) || wrap;
  assign ha_raw = ({1'b0, idx_r} + (CW+1)'(1)) < {1'b0, count_r};
  assign ai_idx = ha_raw ? idx_r + CW'(1) : CW'(1);
  assign ha     = ha_raw || wrap;
  assign spline = pv_r.spl || nxe_r.spl;

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:  rd_addr = idx_r[AW-1:0];
      RD_JM1:  rd_addr = AW'(j_r - CW'(1));
      RD_PV:   rd_addr = pv_idx[AW-1:0];
      RD_BI:   rd_addr = bi_idx[AW-1:0];
      RD_AI:   rd_addr = ai_idx[AW-1:0];
      default: rd_addr = idx_r[AW-1:0];
    endcase
  end

  assign wr_addr = cmd.wr_shift ? j_r[AW-1:0] : idx_r[AW-1:0];
  assign wr_data = cmd.wr_shift ? rd_q_r : item_r;

  // key table
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // table control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.count_clr) begin
      count_r <= '0;
    end else if (cmd.count_inc) begin
      count_r <= count_r + CW'(1);
    end
  end

  // item, search and fetch registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      func_r <= func;
      item_r <= '{stamp: when_q, ex: entry_x, ey: entry_y, ez: entry_z,
                  lx: leave_x, ly: leave_y, lz: leave_z, spl: spline_sel};
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
      hit_r <= 1'b0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.scan_stop) begin
      nxe_r <= rd_q_r;
      hit_r <= (rd_q_r.stamp == q);
    end
    if (cmd.j_load) begin
      j_r <= count_r;
    end else if (cmd.j_dec) begin
      j_r <= j_r - CW'(1);
    end
    if (cmd.pv_load) pv_r <= rd_q_r;
    if (cmd.bi_load) bi_r <= rd_q_r;
    if (cmd.ai_load) ai_r <= rd_q_r;
  end

  // restoring divider for the blend fraction
  assign rem2     = {rem_r, 1'b0};
  assign rem2_sub = rem2 - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r  <= q - pv_r.stamp;
      den_r  <= nxe_r.stamp - pv_r.stamp;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem2_sub[VW] ? rem2[VW-1:0] : rem2_sub[VW-1:0];
      t_r    <= {t_r[TW-2:0], !rem2_sub[VW]};
      dcnt_r <= dcnt_r + DCW'(1);
    end
  end

  // control points of the current component
  always_comb begin
    p1 = leave_of(pv_r, comp_r);
    p2 = entry_of(nxe_r, comp_r);
    p0 = (hb && !distinct(pv_r)) ? leave_of(bi_r, comp_r) : p1;
    p3 = (ha && !distinct(nxe_r)) ? entry_of(ai_r, comp_r) : p2;
  end

  assign p0e    = HW'(p0);
  assign p1e    = HW'(p1);
  assign p2e    = HW'(p2);
  assign p3e    = HW'(p3);
  assign d0     = p2e - p0e;
  assign d1     = p3e - p1e;
  assign dd     = p2e - p1e;
  assign coef_a = (p1e <<< 2) - (p2e <<< 2) + d0 + d1;
  assign coef_b = (dd <<< 2) + (dd <<< 1) - (d0 <<< 1) - d1;
  assign init_v = spline ? coef_a : dd;

  always_comb begin
    if (!spline) begin
      coef = p1e;
    end else begin
      case (step_r)
        2'd0:    coef = coef_b;
        2'd1:    coef = d0;
        default: coef = p1e <<< 1;
      endcase
    end
  end

  assign prod_sh = $signed(prod_r[TW +: HW]);
  assign fin_v   = spline ? (h_r >>> 1) : h_r;

  // horner unit: one multiply, then shift and add
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      comp_r <= '0;
    end else if (cmd.ar_store) begin
      comp_r <= comp_r + 2'd1;
    end
    if (cmd.ar_init) begin
      h_r    <= init_v;
      step_r <= '0;
    end else if (cmd.ar_add) begin
      h_r    <= prod_sh + coef;
      step_r <= step_r + 2'd1;
    end
    if (cmd.ar_mul) begin
      prod_r <= h_r * $signed({1'b0, t_r});
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status_r <= cmd.stat;
      case (cmd.res_sel)
        RES_NX_LEAVE: begin
          res_r[0] <= nxe_r.lx; res_r[1] <= nxe_r.ly; res_r[2] <= nxe_r.lz;
        end
        RES_NX_ENTRY: begin
          res_r[0] <= nxe_r.ex; res_r[1] <= nxe_r.ey; res_r[2] <= nxe_r.ez;
        end
        RES_PV_LEAVE: begin
          res_r[0] <= pv_r.lx; res_r[1] <= pv_r.ly; res_r[2] <= pv_r.lz;
        end
        default: begin
          res_r[0] <= '0; res_r[1] <= '0; res_r[2] <= '0;
        end
      endcase
    end else if (cmd.ar_store) begin
      res_r[comp_r] <= sat_v(fin_v);
      status_r      <= ST_OK;
    end
    if (cmd.out_load) begin
      out_x_r  <= res_r[0];
      out_y_r  <= res_r[1];
      out_z_r  <= res_r[2];
      out_st_r <= status_r;
    end
  end

  assign res_x  = out_x_r;
  assign res_y  = out_y_r;
  assign res_z  = out_z_r;
  assign status = out_st_r;

  // status toward the controller
  assign stat.func       = func_t'(func_r);
  assign stat.when_neg   = item_r.stamp[VW-1];
  assign stat.count_zero = (count_r == '0);
  assign stat.full       = (count_r == CW'(KEYS));
  assign stat.idx_at_end = (idx_r == count_r);
  assign stat.idx_zero   = (idx_r == '0);
  assign stat.stamp_lt   = (rd_q_r.stamp < q);
  assign stat.hit        = hit_r;
  assign stat.j_eq_idx   = (j_r == idx_r);
  assign stat.div_last   = (dcnt_r == DCW'(TW - 1));
  assign stat.step_last  = spline ? (step_r == 2'd2) : (step_r == 2'd0);
  assign stat.comp_last  = (comp_r == 2'd2);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(KEYS))
    else $error("key count beyond table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r == '0 || count_r == $past(count_r)
                     || count_r == $past(count_r) + CW'(1))
    else $error("key count moved by more than one");

endmodule
